// ===== hw/rtl/parbt_pkg.sv =====
// ----------------------------------------------------------------------------
// parbt_pkg
// Shared constants and codes of the per-address rate ban table.
// ----------------------------------------------------------------------------
package parbt_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_HITS      = 16;
	localparam int EW = $clog2(TABLE_ENTRIES);
	localparam int HW = $clog2(MAX_HITS);
	localparam int CW = $clog2(MAX_HITS + 1);

	typedef enum logic [2:0] {
		ST_EXEMPT  = 3'd0,
		ST_COUNTED = 3'd1,
		ST_BAN     = 3'd2,
		ST_BANNED  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	localparam logic [2:0] REG_WINDOW = 3'd0;
	localparam logic [2:0] REG_LIMIT  = 3'd1;
	localparam logic [2:0] REG_EXEN   = 3'd2;
	localparam logic [2:0] REG_EXBASE = 3'd3;
	localparam logic [2:0] REG_EXLEN  = 3'd4;

	typedef struct packed {
		logic [31:0] window_seconds;
		logic [3:0]  hit_limit;
		logic        exempt_enable;
		logic [31:0] exempt_base;
		logic [5:0]  exempt_prefix_len;
	} cfg_t;
endpackage

// ===== hw/rtl/parbt_if.sv =====
// ----------------------------------------------------------------------------
// parbt_in_if / parbt_out_if
// Valid/ready channels for detection events and results.
// ----------------------------------------------------------------------------
interface parbt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [31:0] now_seconds;
	modport source (output valid, address, now_seconds, input ready);
	modport sink (input valid, address, now_seconds, output ready);
endinterface

interface parbt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  hits_in_window;
	logic [31:0] ban_address;
	modport source (output valid, status, hits_in_window, ban_address, input ready);
	modport sink (input valid, status, hits_in_window, ban_address, output ready);
endinterface

// ===== hw/rtl/parbt_cfg.sv =====
// ----------------------------------------------------------------------------
// parbt_cfg
// Configuration register bank.
// ----------------------------------------------------------------------------
module parbt_cfg import parbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds    <= 32'd60;
			cfg_q.hit_limit         <= 4'd5;
			cfg_q.exempt_enable     <= 1'b0;
			cfg_q.exempt_base       <= 32'd0;
			cfg_q.exempt_prefix_len <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW: cfg_q.window_seconds    <= cfg_data;
				REG_LIMIT:  cfg_q.hit_limit         <= cfg_data[3:0];
				REG_EXEN:   cfg_q.exempt_enable     <= cfg_data[0];
				REG_EXBASE: cfg_q.exempt_base       <= cfg_data;
				REG_EXLEN:  cfg_q.exempt_prefix_len <= cfg_data[5:0];
				default: ;
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

// ===== hw/rtl/per_address_rate_ban_table.sv =====
// ----------------------------------------------------------------------------
// per_address_rate_ban_table
// Sliding-window rate limiter over a table of IPv4 addresses.
// Each event runs a key scan over the table; a counted address then has its logged
// times older than the window pruned and its entry and new time written back, while
// an exempt, banned or table-full address goes straight to the result.
// One transaction at a time; the next is accepted the cycle after the
// result is taken, so the key scan and pruning set how often events are taken.
// Reset clears the valid and banned flags; the entry and time memories are left
// undefined and read only for valid entries and kept times.
// ----------------------------------------------------------------------------
module per_address_rate_ban_table import parbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	parbt_in_if.sink    in_ch,
	parbt_out_if.source out_ch
);
	cfg_t cfg;
	parbt_cfg u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PRUNE, S_WRITE, S_OUT} state_t;
	state_t state_q;

	typedef struct packed {
		logic [31:0]   key;
		logic [HW-1:0] head;
		logic [CW-1:0] count;
	} entry_t;

	entry_t      key_mem [TABLE_ENTRIES];
	logic [31:0] time_mem [TABLE_ENTRIES*MAX_HITS];
	logic [TABLE_ENTRIES-1:0] valid_q, banned_q;

	entry_t key_rd_q;
	logic [31:0] addr_q, now_q, time_rd_q;
	logic [EW:0] scan_q;
	logic [EW-1:0] ent_q, free_q;
	logic free_ok_q, rd_pend_q;
	logic [HW-1:0] head_w_q;
	logic [CW-1:0] cnt_w_q;
	logic [2:0] status_q;
	logic [4:0] hits_q;
	logic [31:0] ban_q;
	logic [EW-1:0] key_ra;
	logic [EW+HW-1:0] time_ra;

	// exemption match
	logic [5:0]  plen;
	logic [31:0] pmask;
	logic        exempt;
	always_comb begin
		plen = (cfg.exempt_prefix_len > 6'd32) ? 6'd32 : cfg.exempt_prefix_len;
		pmask = (plen == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - plen));
		exempt = cfg.exempt_enable && (((in_ch.address ^ cfg.exempt_base) & pmask) == 32'd0);
	end

	logic [31:0] thr;
	logic        prune_on;
	assign prune_on = now_q >= cfg.window_seconds;
	assign thr = now_q - cfg.window_seconds;

	logic [EW-1:0] sidx;
	assign sidx = scan_q[EW-1:0];
	assign key_ra = sidx;
	assign time_ra = {ent_q, head_w_q};

	logic key_hit;
	assign key_hit = rd_pend_q && valid_q[ent_q] && (key_rd_q.key == addr_q);

	always_ff @(posedge clk) begin
		key_rd_q  <= key_mem[key_ra];
		time_rd_q <= time_mem[time_ra];
	end

	logic [HW-1:0] tail;
	assign tail = head_w_q + cnt_w_q[HW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && scan_q[EW] && free_ok_q && !key_hit)
			key_mem[free_q] <= '{key: addr_q, head: '0, count: '0};
		else if (state_q == S_WRITE)
			key_mem[ent_q] <= '{key: addr_q, head: head_w_q, count: cnt_w_q + 1'b1};
		if (state_q == S_WRITE) time_mem[{ent_q, tail}] <= now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			banned_q <= '0;
			scan_q <= '0;
			rd_pend_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					addr_q <= in_ch.address;
					now_q <= in_ch.now_seconds;
					hits_q <= 5'd0;
					ban_q <= 32'd0;
					if (exempt) begin
						status_q <= ST_EXEMPT;
						state_q <= S_OUT;
					end else begin
						scan_q <= '0;
						rd_pend_q <= 1'b0;
						free_ok_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// check entry read in the previous cycle
					if (key_hit) begin
						rd_pend_q <= 1'b0;
						if (banned_q[ent_q]) begin
							status_q <= ST_BANNED;
							hits_q <= 5'(key_rd_q.count);
							state_q <= S_OUT;
						end else begin
							head_w_q <= key_rd_q.head;
							cnt_w_q <= key_rd_q.count;
							state_q <= S_PRUNE;
						end
					end else if (scan_q[EW]) begin
						if (free_ok_q) begin
							ent_q <= free_q;
							valid_q[free_q] <= 1'b1;
							banned_q[free_q] <= 1'b0;
							head_w_q <= '0;
							cnt_w_q <= '0;
							state_q <= S_PRUNE;
						end else begin
							status_q <= ST_FULL;
							state_q <= S_OUT;
						end
					end else begin
						if (!valid_q[sidx] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= sidx;
						end
						ent_q <= sidx;
						rd_pend_q <= valid_q[sidx];
						scan_q <= scan_q + 1'b1;
					end
				end
				S_PRUNE: begin
					// time_rd_q is valid the cycle after head_w_q settles
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (prune_on && cnt_w_q != '0 && time_rd_q < thr) begin
						head_w_q <= head_w_q + 1'b1;
						cnt_w_q <= cnt_w_q - 1'b1;
						rd_pend_q <= 1'b0;
					end else begin
						if (cnt_w_q == CW'(MAX_HITS)) begin
							head_w_q <= head_w_q + 1'b1;
							cnt_w_q <= cnt_w_q - 1'b1;
						end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					hits_q <= 5'(cnt_w_q + 1'b1);
					if ((5'(cnt_w_q) + 5'd1) > {1'b0, cfg.hit_limit}) begin
						banned_q[ent_q] <= 1'b1;
						status_q <= ST_BAN;
						ban_q <= addr_q;
					end else status_q <= ST_COUNTED;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.status = status_q;
	assign out_ch.hits_in_window = hits_q;
	assign out_ch.ban_address = ban_q;

	a_ban_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_BAN |-> out_ch.ban_address == addr_q)
		else $error("ban address mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("accept while result pending");
	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_COUNTED |-> out_ch.hits_in_window != 5'd0)
		else $error("counted with zero hits");
endmodule

// ===== dv/parbt_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parbt_tb_if
// Testbench-side copies are not needed; the RTL interfaces are reused.
// This file carries the per-side idle drawing helper for the rate ban table.
// ----------------------------------------------------------------------------
package parbt_tb_pkg;
	function automatic int draw_idle();
		int sel;
		sel = $urandom_range(0, 3);
		if (sel == 0) begin
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction
endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives detection events into the rate ban table through directed and
// random phases under several register settings, and compares every result
// transaction with an in-bench model of the table, window and ban logic.
// ----------------------------------------------------------------------------
module testbench;
	import parbt_pkg::*;
	import parbt_tb_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  hits;
		logic [31:0] ban;
	} verdict_t;

	typedef struct {
		logic [31:0] address;
		logic [31:0] now_s;
		bit          typed;
		verdict_t    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_WINDOW;
	logic [31:0] cfg_data = '0;

	parbt_in_if in_ch ();
	parbt_out_if out_ch ();

	per_address_rate_ban_table i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// model state
	cfg_t        regs;
	logic [31:0] keys [TABLE_ENTRIES];
	bit          used [TABLE_ENTRIES];
	bit          banned [TABLE_ENTRIES];
	logic [31:0] stamps [TABLE_ENTRIES][MAX_HITS];
	int          head [TABLE_ENTRIES];
	int          cnt [TABLE_ENTRIES];

	localparam int PEND_DEPTH = 4096;
	verdict_t pending_verdicts [PEND_DEPTH];
	int pend_wr = 0;
	int pend_rd = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_bans = 0;
	int n_full = 0;
	longint cycles = 0;
	bit sending_done = 1'b0;
	logic [31:0] clock_s = 0;
	logic [31:0] addr_pool [8];

	function automatic bit exempted(logic [31:0] a);
		int len;
		logic [31:0] mask;
		len = regs.exempt_prefix_len > 32 ? 32 : int'(regs.exempt_prefix_len);
		mask = len == 0 ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
		return regs.exempt_enable && (((a ^ regs.exempt_base) & mask) == 0);
	endfunction

	function automatic verdict_t rate_judge(logic [31:0] a, logic [31:0] t);
		verdict_t v;
		int hit_e, free_e, h, c, tl;
		logic [31:0] thr;
		v = '0;
		hit_e = -1;
		free_e = -1;
		if (exempted(a)) begin
			v.status = ST_EXEMPT;
			return v;
		end
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (used[i]) begin
				if (keys[i] == a && hit_e < 0) hit_e = i;
			end else if (free_e < 0) begin
				free_e = i;
			end
		end
		if (hit_e < 0 && free_e >= 0) begin
			hit_e = free_e;
			used[hit_e] = 1;
			banned[hit_e] = 0;
			keys[hit_e] = a;
			head[hit_e] = 0;
			cnt[hit_e] = 0;
		end
		if (hit_e < 0) begin
			v.status = ST_FULL;
			return v;
		end
		if (banned[hit_e]) begin
			v.status = ST_BANNED;
			v.hits = 5'(cnt[hit_e]);
			return v;
		end
		h = head[hit_e];
		c = cnt[hit_e];
		if (t >= regs.window_seconds) begin
			thr = t - regs.window_seconds;
			while (c > 0 && stamps[hit_e][h] < thr) begin
				h = (h + 1) % MAX_HITS;
				c--;
			end
		end
		if (c == MAX_HITS) begin
			h = (h + 1) % MAX_HITS;
			c--;
		end
		tl = (h + c) % MAX_HITS;
		stamps[hit_e][tl] = t;
		c++;
		head[hit_e] = h;
		cnt[hit_e] = c;
		v.hits = 5'(c);
		if (c > regs.hit_limit) begin
			banned[hit_e] = 1;
			v.status = ST_BAN;
			v.ban = a;
		end else begin
			v.status = ST_COUNTED;
		end
		return v;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		in_ch.valid <= 1'b0;
		while (pend_wr != pend_rd) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WINDOW: regs.window_seconds = val;
			REG_LIMIT:  regs.hit_limit = val[3:0];
			REG_EXEN:   regs.exempt_enable = val[0];
			REG_EXBASE: regs.exempt_base = val;
			REG_EXLEN:  regs.exempt_prefix_len = val[5:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pend_wr != pend_rd) @(posedge clk);
		repeat (TABLE_ENTRIES + MAX_HITS + 8) @(posedge clk);
	endtask

	task automatic send_event(logic [31:0] a, logic [31:0] t, bit typed, verdict_t want);
		verdict_t got;
		int n_idle;
		n_idle = draw_idle();
		if (n_idle > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n_idle) @(posedge clk);
		end
		got = rate_judge(a, t);
		if (typed && got !== want) begin
			$display("%0t: directed row disagrees: expected %h actual %h", $time, want, got);
			errors++;
		end
		pending_verdicts[pend_wr % PEND_DEPTH] = got;
		pend_wr++;
		in_ch.valid <= 1'b1;
		in_ch.address <= a;
		in_ch.now_seconds <= t;
		do @(posedge clk); while (!in_ch.ready);
		n_sent++;
	endtask

	task automatic fresh_table();
		// new table contents cannot be cleared without reset; use a new address range
		for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
	endtask

	task automatic random_phase(int items);
		logic [31:0] a, step;
		int sel;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) a = addr_pool[$urandom_range(0, 7)];
			else if (sel < 9) a = $urandom();
			else a = regs.exempt_base ^ ($urandom() >> $urandom_range(0, 32));
			step = $urandom_range(0, 3) == 0 ? $urandom_range(0, 200) :
				$urandom_range(0, 6);
			if ($urandom_range(0, 40) == 0) step = $urandom();
			clock_s = clock_s + step;
			send_event(a, clock_s, 0, '0);
		end
	endtask

	// result side
	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.status, out_ch.hits_in_window, out_ch.ban_address};
				if (pend_wr == pend_rd) begin
					$display("%0t: unexpected result: expected none actual %h", $time, got);
					errors++;
				end else begin
					exp_v = pending_verdicts[pend_rd % PEND_DEPTH];
					pend_rd++;
					n_checked++;
					if (got.status == ST_BAN) n_bans++;
					if (got.status == ST_FULL) n_full++;
					if (got.status !== exp_v.status)
						$display("%0t: status expected %0d actual %0d", $time,
							exp_v.status, got.status);
					if (got.hits !== exp_v.hits)
						$display("%0t: hits expected %0d actual %0d", $time,
							exp_v.hits, got.hits);
					if (got.ban !== exp_v.ban)
						$display("%0t: ban_address expected %h actual %h", $time,
							exp_v.ban, got.ban);
					if (got !== exp_v) errors++;
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (out_ch.ready && out_ch.valid) begin
			stall_left <= draw_idle();
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	row_t rows [$];

	initial begin
		row_t r;
		in_ch.valid = 1'b0;
		in_ch.address = '0;
		in_ch.now_seconds = '0;
		regs = '{window_seconds: 60, hit_limit: 5, exempt_enable: 0,
			exempt_base: 0, exempt_prefix_len: 32};
		foreach (used[i]) begin
			used[i] = 0; banned[i] = 0; head[i] = 0; cnt[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, extremes, ban, banned, window edge
		rows = '{
			'{32'h0000_0000, 32'h0000_0000, 1, '{ST_COUNTED, 5'd1, 32'h0}},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{ST_COUNTED, 5'd1, 32'h0}},
			'{32'hA5A5_5A5A, 32'd10, 1, '{ST_COUNTED, 5'd1, 32'h0}},
			'{32'hA5A5_5A5A, 32'd11, 1, '{ST_COUNTED, 5'd2, 32'h0}},
			'{32'hA5A5_5A5A, 32'd12, 1, '{ST_COUNTED, 5'd3, 32'h0}},
			'{32'hA5A5_5A5A, 32'd13, 1, '{ST_COUNTED, 5'd4, 32'h0}},
			'{32'hA5A5_5A5A, 32'd14, 1, '{ST_COUNTED, 5'd5, 32'h0}},
			'{32'hA5A5_5A5A, 32'd15, 1, '{ST_BAN, 5'd6, 32'hA5A5_5A5A}},
			'{32'hA5A5_5A5A, 32'd16, 1, '{ST_BANNED, 5'd6, 32'h0}},
			'{32'h5A5A_A5A5, 32'd100, 0, '{ST_EXEMPT, 5'd0, 32'h0}},
			'{32'h5A5A_A5A5, 32'd200, 1, '{ST_COUNTED, 5'd1, 32'h0}},
			'{32'h5A5A_A5A5, 32'd260, 0, '{ST_EXEMPT, 5'd0, 32'h0}},
			'{32'h5A5A_A5A5, 32'd261, 0, '{ST_EXEMPT, 5'd0, 32'h0}}
		};
		foreach (rows[i]) send_event(rows[i].address, rows[i].now_s, rows[i].typed,
			rows[i].want);
		drain();

		// exemption extremes
		write_reg(REG_EXEN, 1);
		write_reg(REG_EXBASE, 32'hC0A8_0000);
		write_reg(REG_EXLEN, 16);
		send_event(32'hC0A8_1234, 32'd300, 1, '{ST_EXEMPT, 5'd0, 32'h0});
		send_event(32'hC0A9_1234, 32'd300, 0, '0);
		write_reg(REG_EXLEN, 0);
		send_event(32'h1234_5678, 32'd301, 1, '{ST_EXEMPT, 5'd0, 32'h0});
		write_reg(REG_EXLEN, 63);
		send_event(32'hC0A8_0000, 32'd302, 1, '{ST_EXEMPT, 5'd0, 32'h0});
		send_event(32'hC0A8_0001, 32'd302, 0, '0);
		write_reg(REG_EXEN, 0);
		drain();

		// hit count past the top limit with huge window
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 15);
		for (int k = 0; k < 20; k++) send_event(32'h0BAD_F00D, 32'd400 + k, 0, '0);
		drain();

		// random phases across settings
		clock_s = 1000;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_WINDOW, ph == 0 ? 0 : ph == 1 ? 32'hFFFF_FFFF :
				$urandom_range(1, 100));
			write_reg(REG_LIMIT, ph == 0 ? 0 : ph == 1 ? 15 : $urandom_range(0, 15));
			write_reg(REG_EXEN, $urandom_range(0, 1));
			write_reg(REG_EXBASE, $urandom());
			write_reg(REG_EXLEN, $urandom_range(0, 40));
			fresh_table();
			random_phase(ph == 5 ? 400 : 220);
			drain();
		end
		sending_done = 1;

		$display("Sent %0d events, checked %0d results (%0d bans, %0d table-full drops).",
			n_sent, n_checked, n_bans, n_full);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/parbt_pkg.sv
hw/rtl/parbt_if.sv
hw/rtl/parbt_cfg.sv
hw/rtl/per_address_rate_ban_table.sv
dv/parbt_tb_if.sv
dv/testbench.sv
